### rtl/core/assert_macros.svh
// assertion helpers shared by the rtl files
// no dependencies; clocked on posedge, reset active low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// explicit clock and active-low reset
`define ASSERT_CLK(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// block clock clk and reset arst_n
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

### rtl/core/bsw_pkg.sv
// shared constants, types and helpers of the bmp stream writer
// no dependencies
`timescale 1ns / 1ps

package bsw_pkg;

	localparam int MAX_SIDE   = 16384;
	localparam int HDR_BYTES  = 54;
	localparam int INFO_BYTES = 40;
	localparam int BMP_MAGIC  = 16'h4d42;
	localparam int PIX_PER_M  = 2835;
	localparam int HDR_WORDS  = 14;
	localparam int TASK_DEPTH = 4;
	localparam int TASK_AW    = $clog2(TASK_DEPTH);

	localparam logic [1:0] REG_WIDTH   = 2'd0;
	localparam logic [1:0] REG_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_SRC_BPP = 2'd2;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// one unit of work handed from front to back
	// header: a = data size; pixel: a = file offset, b = pixel word
	typedef struct packed {
		logic        is_hdr;
		logic        depth4;
		logic        row_end;
		logic [1:0]  pad;
		logic [14:0] width;
		logic [14:0] height;
		logic [31:0] a;
		logic [31:0] b;
	} task_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

	function automatic logic [14:0] clamp_side(input logic [14:0] v);
		logic [14:0] r;
		r = v;
		if (v == 15'd0)
			r = 15'd1;
		else if (int'(v) > MAX_SIDE)
			r = 15'(MAX_SIDE);
		return r;
	endfunction

	function automatic logic [4:0] clamp_src(input logic [4:0] v);
		logic [4:0] r;
		r = v;
		if (v == 5'd0)
			r = 5'd1;
		else if (v > 5'd16)
			r = 5'd16;
		return r;
	endfunction

endpackage

### rtl/core/bsw_front.sv
// front end: configuration registers, frame bookkeeping, task generation
// depends on bsw_pkg
`timescale 1ns / 1ps

module bsw_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [14:0]        cfg_data,
	input  logic               push,
	output logic               full,
	input  logic               command,
	input  logic [31:0]        pixel_bytes,
	input  bsw_pkg::fifo_stat_t fifo_stat,
	output logic               task_push,
	output bsw_pkg::task_t     task_o
);
	import bsw_pkg::*;

	localparam logic F_IDLE = 1'b0;
	localparam logic F_CALC = 1'b1;

	logic        state_q;
	logic [14:0] width_q, height_q;
	logic [4:0]  src_bpp_q;

	logic [14:0] w_q, ht_q;
	logic [4:0]  src_q;
	logic        d4_q;
	logic [16:0] pitch_q;
	logic [1:0]  pad_q;
	logic        active_q;
	logic [31:0] row_base_q;
	logic [14:0] column_q;
	logic [16:0] col_off_q;
	logic [14:0] rows_left_q;

	logic [14:0] w_c, ht_c;
	logic [4:0]  src_c;
	logic        d4_c;
	logic [16:0] line_c, pitch_c;
	logic [1:0]  pad_c;
	logic [31:0] ds_c, rb_c, off_c, data_c;
	logic [7:0]  b0;
	logic        accept, is_pix, row_end;
	logic [16:0] depth_c;

	assign full   = (state_q != F_IDLE) || fifo_stat.full;
	assign accept = push && !full;
	assign is_pix = accept && (command == CMD_PIXEL) && active_q;

	always_comb begin
		w_c     = clamp_side(width_q);
		ht_c    = clamp_side(height_q);
		src_c   = clamp_src(src_bpp_q);
		d4_c    = src_c > 5'd4;
		line_c  = d4_c ? {w_c, 2'b00} : ({2'b00, w_c} + {1'b0, w_c, 1'b0});
		pad_c   = 2'd0 - line_c[1:0];
		pitch_c = line_c + {15'd0, pad_c};
	end

	// frame geometry, used in the F_CALC state of a start
	assign ds_c = {17'd0, ht_q} * {15'd0, pitch_q};
	assign rb_c = ds_c - {15'd0, pitch_q} + 32'(HDR_BYTES);

	assign depth_c = d4_q ? 17'd4 : 17'd3;
	assign off_c   = row_base_q + {15'd0, col_off_q};
	assign row_end = column_q == (w_q - 15'd1);
	assign b0      = pixel_bytes[7:0];

	always_comb begin
		if (d4_q)
			data_c = pixel_bytes;
		else if (src_q >= 5'd3)
			data_c = {8'd0, pixel_bytes[23:0]};
		else if (src_q == 5'd2)
			data_c = {8'd0, b0, pixel_bytes[15:0]};
		else
			data_c = {8'd0, b0, b0, b0};
	end

	always_comb begin
		task_push      = 1'b0;
		task_o.is_hdr  = 1'b0;
		task_o.depth4  = d4_q;
		task_o.row_end = row_end;
		task_o.pad     = pad_q;
		task_o.width   = w_q;
		task_o.height  = ht_q;
		task_o.a       = off_c;
		task_o.b       = data_c;
		if (state_q == F_CALC) begin
			task_push     = 1'b1;
			task_o.is_hdr = 1'b1;
			task_o.a      = ds_c;
			task_o.b      = 32'd0;
		end else if (is_pix) begin
			task_push = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			width_q     <= 15'd1;
			height_q    <= 15'd1;
			src_bpp_q   <= 5'd3;
			w_q         <= 15'd0;
			ht_q        <= 15'd0;
			src_q       <= 5'd0;
			d4_q        <= 1'b0;
			pitch_q     <= 17'd0;
			pad_q       <= 2'd0;
			active_q    <= 1'b0;
			row_base_q  <= 32'd0;
			column_q    <= 15'd0;
			col_off_q   <= 17'd0;
			rows_left_q <= 15'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:   width_q   <= cfg_data;
					REG_HEIGHT:  height_q  <= cfg_data;
					REG_SRC_BPP: src_bpp_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			case (state_q)
				F_IDLE: begin
					if (accept && command == CMD_START) begin
						w_q         <= w_c;
						ht_q        <= ht_c;
						src_q       <= src_c;
						d4_q        <= d4_c;
						pitch_q     <= pitch_c;
						pad_q       <= pad_c;
						rows_left_q <= ht_c;
						column_q    <= 15'd0;
						col_off_q   <= 17'd0;
						active_q    <= 1'b0;
						state_q     <= F_CALC;
					end else if (is_pix) begin
						if (row_end) begin
							column_q    <= 15'd0;
							col_off_q   <= 17'd0;
							rows_left_q <= rows_left_q - 15'd1;
							if (rows_left_q == 15'd1)
								active_q <= 1'b0;
							else
								row_base_q <= row_base_q - {15'd0, pitch_q};
						end else begin
							column_q  <= column_q + 15'd1;
							col_off_q <= col_off_q + depth_c;
						end
					end
				end
				F_CALC: begin
					row_base_q <= rb_c;
					active_q   <= 1'b1;
					state_q    <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/bsw_task_fifo.sv
// short task queue between front and back
// depends on bsw_pkg
`timescale 1ns / 1ps

module bsw_task_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  bsw_pkg::task_t      wr_task,
	input  logic                rd_en,
	output bsw_pkg::task_t      rd_task,
	output bsw_pkg::fifo_stat_t stat
);
	import bsw_pkg::*;

	task_t                mem_q [TASK_DEPTH];
	logic [TASK_AW-1:0]   wptr_q, rptr_q;
	logic [TASK_AW:0]     count_q;
	logic                 do_wr, do_rd;

	assign stat.empty = count_q == '0;
	assign stat.full  = count_q == (TASK_AW+1)'(TASK_DEPTH);
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign rd_task    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wr_task;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr)
				wptr_q <= (wptr_q == TASK_AW'(TASK_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_rd)
				rptr_q <= (rptr_q == TASK_AW'(TASK_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

### rtl/core/bsw_back.sv
// back end: expands tasks into file writes, holds the result register
// depends on bsw_pkg
`timescale 1ns / 1ps

module bsw_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bsw_pkg::task_t      head,
	input  bsw_pkg::fifo_stat_t fifo_stat,
	output logic                task_pop,
	output logic                empty,
	input  logic                pop,
	output logic [31:0]         write_offset,
	output logic [31:0]         write_data,
	output logic [2:0]          byte_count,
	output logic                last
);
	import bsw_pkg::*;

	logic [3:0]  idx_q;
	logic        valid_q;
	logic        advance, last_word, has_pad;
	logic [31:0] off_c, data_c, fsize;
	logic [2:0]  cnt_c;
	logic [15:0] bpp;
	logic [31:0] depth_c;

	assign advance  = !fifo_stat.empty && (!valid_q || pop);
	assign has_pad  = head.row_end && (head.pad != 2'd0);
	assign fsize    = head.a + 32'(HDR_BYTES);
	assign bpp      = head.depth4 ? 16'd32 : 16'd24;
	assign depth_c  = head.depth4 ? 32'd4 : 32'd3;
	assign task_pop = advance && last_word;
	assign empty    = !valid_q;

	always_comb begin
		if (head.is_hdr)
			last_word = idx_q == 4'(HDR_WORDS - 1);
		else
			last_word = (idx_q != 4'd0) || !has_pad;
	end

	always_comb begin
		off_c  = {26'd0, idx_q, 2'b00};
		cnt_c  = 3'd4;
		data_c = 32'd0;
		if (head.is_hdr) begin
			// header word at byte offset 4 * idx
			case (idx_q)
				4'd0:  data_c = {fsize[15:0], 16'(BMP_MAGIC)};
				4'd1:  data_c = {16'd0, fsize[31:16]};
				4'd2:  data_c = {16'(HDR_BYTES), 16'd0};
				4'd3:  data_c = {16'(INFO_BYTES), 16'd0};
				4'd4:  data_c = {1'b0, head.width, 16'd0};
				4'd5:  data_c = {1'b0, head.height, 16'd0};
				4'd6:  data_c = {16'd1, 16'd0};
				4'd7:  data_c = {16'd0, bpp};
				4'd8:  data_c = {head.a[15:0], 16'd0};
				4'd9:  data_c = {16'(PIX_PER_M), head.a[31:16]};
				4'd10: data_c = {16'(PIX_PER_M), 16'd0};
				4'd13: cnt_c  = 3'd2;
				default: data_c = 32'd0;
			endcase
		end else if (idx_q == 4'd0) begin
			off_c  = head.a;
			data_c = head.b;
			cnt_c  = head.depth4 ? 3'd4 : 3'd3;
		end else begin
			// row padding right after the last pixel
			off_c  = head.a + depth_c;
			data_c = 32'd0;
			cnt_c  = {1'b0, head.pad};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			write_offset <= off_c;
			write_data   <= data_c;
			byte_count   <= cnt_c;
			last         <= last_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 4'd0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
				idx_q   <= last_word ? 4'd0 : idx_q + 4'd1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/core/bmp_stream_writer_top.sv
// bmp stream writer, top level: front end, task queue and back end
// A pixel word becomes one task and leaves as one write, two at the end
// of a row that needs padding; the back end's one-word-per-cycle result
// register sets that pace while pop drains it. A start registers the
// geometry, then holds the input in F_CALC for the 15x17 size multiply.
// The back end expands the header into fourteen words; the header task
// holds one of the four queue entries meanwhile, so up to three pixels
// are taken while it is expanded. Configuration is sampled at start.
// depends on bsw_pkg, bsw_front, bsw_task_fifo, bsw_back, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmp_stream_writer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic        command,
	input  logic [31:0] pixel_bytes,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] write_offset,
	output logic [31:0] write_data,
	output logic [2:0]  byte_count,
	output logic        last
);
	import bsw_pkg::*;

	task_t      task_in, task_head;
	fifo_stat_t fifo_stat;
	logic       task_push, task_pop;

	bsw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.command     (command),
		.pixel_bytes (pixel_bytes),
		.fifo_stat   (fifo_stat),
		.task_push   (task_push),
		.task_o      (task_in)
	);

	bsw_task_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (task_push),
		.wr_task (task_in),
		.rd_en   (task_pop),
		.rd_task (task_head),
		.stat    (fifo_stat)
	);

	bsw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (task_head),
		.fifo_stat    (fifo_stat),
		.task_pop     (task_pop),
		.empty        (empty),
		.pop          (pop),
		.write_offset (write_offset),
		.write_data   (write_data),
		.byte_count   (byte_count),
		.last         (last)
	);

	`ASSERT_STD(a_no_push_full, task_push |-> !fifo_stat.full, "task pushed into full queue")
	`ASSERT_STD(a_start_holds, (push && !full && command == CMD_START) |=> full, "start did not stall input")
	`ASSERT_STD(a_count_range, !empty |-> (byte_count != 3'd0 && byte_count <= 3'd4), "bad byte count")
	`ASSERT_STD(a_upper_zero, (!empty && byte_count == 3'd2) |-> (write_data[31:16] == 16'd0), "dirty upper bytes")

endmodule
